// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the parser RTL. They vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an expression on every clock edge outside reset.
`define NPPR_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define NPPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define NPPR_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define NPPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/nppr_pkg.sv =====
// ----------------------------------------------------------------------------
// nppr_pkg
// Types and constants shared by the numeric parameter parser.
// ----------------------------------------------------------------------------
package nppr_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int DIGIT_W = 4;

   // Character codes the classifier looks for
   localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

   // Letter digit: low nibble of 'A'/'a' is 1, so add 9 to reach 10
   localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 4'd9;

   // Character classes produced by the front end
   typedef enum logic [2:0] {
      CLS_END,
      CLS_BLANK,
      CLS_QUOTE,
      CLS_MINUS,
      CLS_DEC,
      CLS_HEXL,
      CLS_X,
      CLS_OTHER
   } cls_type;

   // Classified character as it travels through the queue
   typedef struct packed {
      cls_type            cls;
      logic [DIGIT_W-1:0] digit;
   } tok_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      tok_type tok;
   } head_type;

   // Result classification
   typedef enum logic [1:0] {
      KIND_DEC = 2'd0,
      KIND_HEX = 2'd1,
      KIND_STR = 2'd2,
      KIND_BAD = 2'd3
   } kind_type;

   // Parse phase, one-hot
   typedef enum logic [3:0] {
      PH_SKIP  = 4'b0001,
      PH_DEC   = 4'b0010,
      PH_HEX   = 4'b0100,
      PH_QUOTE = 4'b1000
   } phase_type;

endpackage

// ===== rtl/nppr_if.sv =====
// ----------------------------------------------------------------------------
// nppr_if
// Valid/ready channels of the parser: characters in, results out.
// ----------------------------------------------------------------------------
interface nppr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface nppr_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic signed [31:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/nppr_front.sv =====
// ----------------------------------------------------------------------------
// nppr_front
// Accepts characters and classifies them into tokens for the queue.
// ----------------------------------------------------------------------------
module nppr_front
   import nppr_pkg::*;
(
   nppr_req_if.sink req_bus,
   input  logic     full,
   output logic     push,
   output tok_type  push_tok
);

   logic [CHAR_W-1:0] ch;

   assign ch = req_bus.ch;

   // Take a character whenever the queue has room
   assign req_bus.ready = !full;
   assign push          = req_bus.valid && !full;

   // Classify the character and extract its digit value
   always_comb begin
      push_tok.digit = ch[DIGIT_W-1:0];
      if (ch == CH_END) begin
         push_tok.cls = CLS_END;
      end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
         push_tok.cls = CLS_BLANK;
      end else if (ch == CH_QUOTE) begin
         push_tok.cls = CLS_QUOTE;
      end else if (ch == CH_MINUS) begin
         push_tok.cls = CLS_MINUS;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
         push_tok.cls = CLS_DEC;
      end else if ((ch >= CH_UC_A && ch <= CH_UC_F) || (ch >= CH_LC_A && ch <= CH_LC_F)) begin
         push_tok.cls   = CLS_HEXL;
         push_tok.digit = ch[DIGIT_W-1:0] + LETTER_OFFSET;
      end else if (ch == CH_UC_X || ch == CH_LC_X) begin
         push_tok.cls = CLS_X;
      end else begin
         push_tok.cls = CLS_OTHER;
      end
   end

endmodule

// ===== rtl/nppr_queue.sv =====
// ----------------------------------------------------------------------------
// nppr_queue
// Small token FIFO between the classifier and the parse engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nppr_queue
   import nppr_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  tok_type  push_tok,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tok_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.tok   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed token
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

   `NPPR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_CNT)
   `NPPR_ASSERT_ALWAYS(a_empty_ptrs, clock, reset, (count_ff != '0) || (rd_ptr_ff == wr_ptr_ff))

endmodule

// ===== rtl/nppr_back.sv =====
// ----------------------------------------------------------------------------
// nppr_back
// Parse engine: runs one token a cycle, bar a terminator behind a stalled result; holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nppr_back
   import nppr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  head_type  head,
   output logic      pop,
   nppr_rsp_if.source rsp_bus
);

   phase_type           phase_ff, phase_in;
   logic [1:0]          position_ff, position_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic                negative_ff, negative_in;
   logic                bad_ff, bad_in;
   logic                prev_quote_ff, prev_quote_in;
   logic                prev_zero_ff, prev_zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [VALUE_W-1:0]  value_ff, value_in;

   tok_type             tok;
   logic                is_end;
   logic                out_free;
   logic                taken;
   logic [VALUE_W-1:0]  acc_dec;
   logic [VALUE_W-1:0]  acc_hex;
   kind_type            res_kind;
   logic [VALUE_W-1:0]  res_value;

   assign tok      = head.tok;
   assign is_end   = (tok.cls == CLS_END);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign pop      = head.valid && (!is_end || out_free);

   // Accumulate steps: times ten plus digit, times sixteen plus digit
   assign acc_dec = {acc_ff[VALUE_W-4:0], 3'b000} + {acc_ff[VALUE_W-2:0], 1'b0}
                  + {{(VALUE_W-DIGIT_W){1'b0}}, tok.digit};
   assign acc_hex = {acc_ff[VALUE_W-DIGIT_W-1:0], tok.digit};

   // Form the result from the state at end of string
   always_comb begin
      res_kind  = KIND_BAD;
      res_value = '0;
      if (!bad_ff) begin
         unique case (phase_ff)
            PH_DEC: begin
               res_kind  = KIND_DEC;
               res_value = negative_ff ? (VALUE_W'(0) - acc_ff) : acc_ff;
            end
            PH_HEX: begin
               res_kind  = KIND_HEX;
               res_value = acc_ff;
            end
            PH_QUOTE: begin
               res_kind = prev_quote_ff ? KIND_STR : KIND_BAD;
            end
            default: begin
               res_kind = KIND_BAD;
            end
         endcase
      end
   end

   // Advance the parse state on each popped token
   always_comb begin
      phase_in      = phase_ff;
      position_in   = position_ff;
      acc_in        = acc_ff;
      negative_in   = negative_ff;
      bad_in        = bad_ff;
      prev_quote_in = prev_quote_ff;
      prev_zero_in  = prev_zero_ff;
      taken         = 1'b0;
      if (pop) begin
         if (is_end) begin
            phase_in      = PH_SKIP;
            position_in   = '0;
            acc_in        = '0;
            negative_in   = 1'b0;
            bad_in        = 1'b0;
            prev_quote_in = 1'b0;
            prev_zero_in  = 1'b0;
         end else if (!bad_ff) begin
            taken = 1'b1;
            unique case (phase_ff)
               PH_SKIP: begin
                  case (tok.cls)
                     CLS_BLANK: taken = 1'b0;
                     CLS_QUOTE: phase_in = PH_QUOTE;
                     CLS_MINUS: begin
                        phase_in    = PH_DEC;
                        negative_in = 1'b1;
                     end
                     CLS_DEC: begin
                        phase_in = PH_DEC;
                        acc_in   = {{(VALUE_W-DIGIT_W){1'b0}}, tok.digit};
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
               PH_DEC: begin
                  if (position_ff == 2'd1 && prev_zero_ff && tok.cls == CLS_X) begin
                     phase_in = PH_HEX;
                     acc_in   = '0;
                  end else if (tok.cls == CLS_DEC) begin
                     acc_in = acc_dec;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               PH_HEX: begin
                  case (tok.cls) inside
                     CLS_DEC, CLS_HEXL: acc_in = acc_hex;
                     default:           bad_in = 1'b1;
                  endcase
               end
               PH_QUOTE: begin
                  // only the last character counts
               end
               default: begin
                  bad_in = 1'b1;
               end
            endcase
            if (taken) begin
               prev_quote_in = (tok.cls == CLS_QUOTE);
               prev_zero_in  = (tok.cls == CLS_DEC) && (tok.digit == '0);
               if (position_ff != 2'd3) begin
                  position_in = position_ff + 2'd1;
               end
            end
         end
      end
   end

   // Load the result register at end of string, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      if (pop && is_end) begin
         rsp_valid_in = 1'b1;
         kind_in      = res_kind;
         value_in     = res_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SKIP;
         position_ff   <= '0;
         acc_ff        <= '0;
         negative_ff   <= 1'b0;
         bad_ff        <= 1'b0;
         prev_quote_ff <= 1'b0;
         prev_zero_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         acc_ff        <= acc_in;
         negative_ff   <= negative_in;
         bad_ff        <= bad_in;
         prev_quote_ff <= prev_quote_in;
         prev_zero_ff  <= prev_zero_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.kind  = kind_ff;
   assign rsp_bus.value = value_ff;

   `NPPR_ASSERT_ALWAYS(a_phase_onehot, clock, reset, $onehot(phase_ff))
   `NPPR_ASSERT_ALWAYS(a_end_needs_room, clock, reset, !(pop && is_end) || out_free)
   `NPPR_ASSERT_NEXT(a_end_clears, clock, reset, pop && is_end, (phase_ff == PH_SKIP) && !bad_ff && (acc_ff == '0) && rsp_valid_ff)

endmodule

// ===== rtl/numeric_parameter_parser.sv =====
// ----------------------------------------------------------------------------
// numeric_parameter_parser
// Parses a zero-terminated parameter string into a decimal, hex, quoted
// string or bad classification with a signed 32-bit value.
//
//   channel   dir  payload            transfer
//   req_bus   in   ch[7:0]            one character, 0 ends the string
//   rsp_bus   out  kind[1:0], value   one result per terminated string
//
// One character per cycle while the queue has room; a terminating
// character is written into the queue on its transfer edge and is then
// parsed into the result register of the parse engine.
// The parse engine's state update sets the rate.
// The token queue holds QUEUE_DEPTH characters; a stalled result holds the
// next terminator at the queue head, characters ahead of it keep draining.
// Synchronous reset returns the parser to the leading-whitespace phase.
// ----------------------------------------------------------------------------
module numeric_parameter_parser
   import nppr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   nppr_req_if.sink    req_bus,
   nppr_rsp_if.source  rsp_bus
);

   logic     push;
   tok_type  push_tok;
   logic     full;
   logic     pop;
   head_type head;

   // Classify incoming characters
   nppr_front u_front (
      .req_bus  (req_bus),
      .full     (full),
      .push     (push),
      .push_tok (push_tok)
   );

   // Buffer tokens between front and back
   nppr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .full     (full),
      .pop      (pop),
      .head     (head)
   );

   // Parse tokens and deliver results
   nppr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
